>>> hw/rtl/aist_pkg.sv
package aist_pkg;

   localparam int unsigned DATA_W = 32;

   localparam logic signed [DATA_W-1:0] OBJ_MAX = 32'sh7FFF_FFFF;

   // Configuration register indexes and reset values.
   localparam logic [1:0] CSR_STRETCH = 2'd0;
   localparam logic [1:0] CSR_DIM     = 2'd1;
   localparam logic [1:0] CSR_POINTS  = 2'd2;

   localparam logic [15:0] STRETCH_RESET = 16'd512;
   localparam logic [1:0]  DIM_RESET     = 2'd1;
   localparam logic [6:0]  POINTS_RESET  = 7'd8;

   localparam logic [1:0] DIM_ONE = 2'd1;
   localparam logic [1:0] DIM_TWO = 2'd2;

   typedef enum logic [1:0] {
      REQ_LOAD      = 2'd0,
      REQ_RECOMMEND = 2'd1,
      REQ_REPORT    = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_MISMATCH = 2'd1,
      STAT_BAD_DIM  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_IDX,
      RD_CURSOR,
      RD_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      OW_NONE,
      OW_MAX,
      OW_REPORT
   } obj_wr_type;

   typedef enum logic [1:0] {
      SW_NONE,
      SW_LOAD,
      SW_MUL,
      SW_DIV
   } smp_wr_type;

   typedef enum logic [4:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FIRST_RD,
      ST_FIRST_CHK,
      ST_MUL_RD,
      ST_MUL_PROD,
      ST_MUL_WR,
      ST_DIV_RD,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WRAP_CLEAR,
      ST_REC_ADV,
      ST_REC_RD1,
      ST_REC_D1,
      ST_REC_RD2,
      ST_REC_D2,
      ST_REP_RD,
      ST_REP_CHK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       cnt_clr;
      logic       cnt_inc;
      rd_sel_type rd_sel;
      obj_wr_type obj_wr;
      smp_wr_type smp_wr;
      logic       scan_cmp;
      logic       mul_prod;
      logic       div_start;
      logic       cursor_adv;
      logic       set_p1;
      logic       set_p2;
      logic       set_cnt;
      logic       set_status;
      status_type status_val;
      logic       out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] rq_type;
      logic [1:0] dim_mode;
      logic       wrap;
      logic       cursor_none;
      logic       idx_last;
      logic       clear_last;
      logic       do_div;
      logic       do_mul;
      logic       div_done;
      logic       param_match;
      logic       out_free;
   } ctrl_stat_type;

endpackage

>>> hw/rtl/aist_div.sv
module aist_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  dividend,
   input  logic [15:0]         divisor,
   output logic                done,
   output logic signed [31:0]  quotient
);
   import aist_pkg::*;

   // The dividend is scaled by 256 before division, so the quotient has 40 bits.
   localparam int unsigned STEPS = 40;

   logic [STEPS-1:0] q_ff;
   logic [15:0]      rem_ff;
   logic [15:0]      dvs_ff;
   logic [5:0]       step_ff;
   logic             busy_ff;
   logic             done_ff;
   logic             neg_ff;
   logic             zero_ff;

   logic [31:0] mag;
   logic [16:0] rem_sh;
   logic        ge;
   logic [16:0] rem_sub;

   assign mag     = dividend[31] ? (32'd0 - dividend) : dividend;
   assign rem_sh  = {rem_ff, q_ff[STEPS-1]};
   assign ge      = rem_sh >= {1'b0, dvs_ff};
   assign rem_sub = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 6'd1;
         if (step_ff == 6'(STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff    <= {mag, 8'd0};
         rem_ff  <= '0;
         dvs_ff  <= divisor;
         neg_ff  <= dividend[31];
         zero_ff <= (dividend == '0);
      end else if (busy_ff) begin
         q_ff   <= {q_ff[STEPS-2:0], ge};
         rem_ff <= ge ? rem_sub[15:0] : rem_sh[15:0];
      end
   end

   // A zero divisor yields an all-ones quotient, which saturates by sign as wanted.
   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (neg_ff) begin
         if (q_ff > 40'h00_8000_0000) begin
            quotient = 32'sh8000_0000;
         end else begin
            quotient = 32'd0 - q_ff[31:0];
         end
      end else begin
         if (q_ff > 40'h00_7FFF_FFFF) begin
            quotient = OBJ_MAX;
         end else begin
            quotient = q_ff[31:0];
         end
      end
   end

   assign done = done_ff;

endmodule

>>> hw/rtl/aist_ctrl.sv
module aist_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  aist_pkg::ctrl_stat_type stat,
   output aist_pkg::ctrl_cmd_type  cmd
);
   import aist_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_IDX;
      cmd.obj_wr     = OW_NONE;
      cmd.smp_wr     = SW_NONE;
      cmd.status_val = STAT_OK;
      req_stall      = 1'b1;

      unique case (state_ff)
         ST_INIT_CLEAR: begin
            cmd.obj_wr = OW_MAX;
            if (stat.clear_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (stat.rq_type)
               REQ_LOAD: begin
                  cmd.smp_wr = SW_LOAD;
                  state_in   = ST_OUT;
               end
               REQ_RECOMMEND: begin
                  if (stat.wrap) begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = ST_SCAN_RD;
                  end else begin
                     state_in = ST_REC_ADV;
                  end
               end
               REQ_REPORT: begin
                  if (stat.cursor_none) begin
                     cmd.set_status = 1'b1;
                     cmd.status_val = STAT_MISMATCH;
                     state_in       = ST_OUT;
                  end else begin
                     state_in = ST_REP_RD;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.idx_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_FIRST_RD;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_FIRST_RD: begin
            state_in = ST_FIRST_CHK;
         end
         ST_FIRST_CHK: begin
            if (stat.do_div) begin
               state_in = ST_DIV_RD;
            end else if (stat.do_mul) begin
               state_in = ST_MUL_RD;
            end else begin
               state_in = ST_WRAP_CLEAR;
            end
         end
         ST_MUL_RD: begin
            state_in = ST_MUL_PROD;
         end
         ST_MUL_PROD: begin
            cmd.mul_prod = 1'b1;
            state_in     = ST_MUL_WR;
         end
         ST_MUL_WR: begin
            cmd.smp_wr = SW_MUL;
            if (stat.idx_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_WRAP_CLEAR;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = ST_MUL_RD;
            end
         end
         ST_DIV_RD: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.smp_wr = SW_DIV;
               if (stat.idx_last) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = ST_WRAP_CLEAR;
               end else begin
                  cmd.cnt_inc = 1'b1;
                  state_in    = ST_DIV_RD;
               end
            end
         end
         ST_WRAP_CLEAR: begin
            cmd.obj_wr = OW_MAX;
            if (stat.clear_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = ST_REC_ADV;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_REC_ADV: begin
            cmd.cursor_adv = 1'b1;
            if (stat.dim_mode == DIM_ONE || stat.dim_mode == DIM_TWO) begin
               state_in = ST_REC_RD1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status_val = STAT_BAD_DIM;
               state_in       = ST_OUT;
            end
         end
         ST_REC_RD1: begin
            cmd.rd_sel = RD_CURSOR;
            state_in   = ST_REC_D1;
         end
         ST_REC_D1: begin
            cmd.set_p1  = 1'b1;
            cmd.set_cnt = 1'b1;
            if (stat.dim_mode == DIM_TWO) begin
               state_in = ST_REC_RD2;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_REC_RD2: begin
            cmd.rd_sel = RD_LAST;
            state_in   = ST_REC_D2;
         end
         ST_REC_D2: begin
            cmd.set_p2 = 1'b1;
            state_in   = ST_OUT;
         end
         ST_REP_RD: begin
            cmd.rd_sel = RD_CURSOR;
            state_in   = ST_REP_CHK;
         end
         ST_REP_CHK: begin
            if (stat.param_match) begin
               cmd.obj_wr = OW_REPORT;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status_val = STAT_MISMATCH;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/aist_dpath.sv
module aist_dpath #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_type,
   input  logic [5:0]              req_point_index,
   input  logic signed [31:0]      req_point_value,
   input  logic signed [31:0]      req_reported_param,
   input  logic signed [31:0]      req_objective_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_first_param,
   output logic signed [31:0]      rsp_second_param,
   output logic [1:0]              rsp_param_count,
   output logic [1:0]              rsp_status_code,
   input  aist_pkg::ctrl_cmd_type  cmd,
   output aist_pkg::ctrl_stat_type stat
);
   import aist_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned NW = (CW > 7) ? CW : 7;

   localparam logic signed [47:0] MUL_MAX = 48'sh0000_7FFF_FFFF;
   localparam logic signed [47:0] MUL_MIN = 48'shFFFF_8000_0000;

   // Configuration registers.
   logic [15:0] stretch_ff;
   logic [1:0]  dim_ff;
   logic [6:0]  points_ff;

   // Latched request.
   logic [1:0]         rq_type_ff;
   logic [5:0]         rq_idx_ff;
   logic signed [31:0] rq_pval_ff;
   logic signed [31:0] rq_rparam_ff;
   logic signed [31:0] rq_obj_ff;

   logic [CW-1:0]      idx_ff;
   logic [AW-1:0]      cursor_ff;
   logic               cursor_none_ff;
   logic signed [31:0] init_min_ff;
   logic signed [31:0] best_ff;
   logic [AW-1:0]      low_ff;
   logic signed [47:0] prod_ff;

   logic signed [31:0] smp_mem [TABLE_DEPTH];
   logic signed [31:0] obj_mem [TABLE_DEPTH];
   logic signed [31:0] smp_rd_ff;
   logic signed [31:0] obj_rd_ff;

   logic signed [31:0] res_p1_ff;
   logic signed [31:0] res_p2_ff;
   logic [1:0]         res_cnt_ff;
   logic [1:0]         res_stat_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_p1_ff;
   logic signed [31:0] rsp_p2_ff;
   logic [1:0]         rsp_cnt_ff;
   logic [1:0]         rsp_stat_ff;

   logic [NW-1:0]      points_ext;
   logic [NW-1:0]      used_w;
   logic [CW-1:0]      used_n;
   logic [CW-1:0]      last_w;
   logic [CW-1:0]      next_w;
   logic               wrap;
   logic [NW-1:0]      load_ext;
   logic               load_ok;

   logic [AW-1:0]      smp_ra;
   logic               smp_we;
   logic [AW-1:0]      smp_wa;
   logic signed [31:0] smp_wd;
   logic               obj_we;
   logic [AW-1:0]      obj_wa;
   logic signed [31:0] obj_wd;

   logic signed [47:0] prod_adj;
   logic signed [47:0] prod_sh;
   logic signed [31:0] mul_sat;
   logic               div_done;
   logic signed [31:0] div_quot;

   aist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (smp_rd_ff),
      .divisor  (stretch_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sweep length: zero counts as one, anything past the table as the table.
   assign points_ext = NW'(points_ff);
   assign used_w     = (points_ext == '0) ? NW'(1) :
                       (points_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : points_ext;
   assign used_n     = used_w[CW-1:0];
   assign last_w     = used_n - CW'(1);
   assign next_w     = cursor_none_ff ? '0 : (CW'(cursor_ff) + CW'(1));
   assign wrap       = next_w >= used_n;
   assign load_ext   = NW'(rq_idx_ff);
   assign load_ok    = load_ext < NW'(TABLE_DEPTH);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stretch_ff <= STRETCH_RESET;
         dim_ff     <= DIM_RESET;
         points_ff  <= POINTS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STRETCH: stretch_ff <= csr_wdata;
            CSR_DIM:     dim_ff     <= csr_wdata[1:0];
            CSR_POINTS:  points_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         rq_type_ff   <= req_type;
         rq_idx_ff    <= req_point_index;
         rq_pval_ff   <= req_point_value;
         rq_rparam_ff <= req_reported_param;
         rq_obj_ff    <= req_objective_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         cursor_ff      <= '0;
         cursor_none_ff <= 1'b1;
         init_min_ff    <= '0;
      end else begin
         if (cmd.cnt_clr) begin
            idx_ff <= '0;
         end else if (cmd.cnt_inc) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.cursor_adv) begin
            cursor_none_ff <= 1'b0;
            cursor_ff      <= wrap ? '0 : next_w[AW-1:0];
         end
         if (cmd.smp_wr == SW_LOAD && load_ok && rq_idx_ff == '0) begin
            init_min_ff <= rq_pval_ff;
         end
      end
   end

   // Minimum search keeps the first entry with the least objective.
   always_ff @(posedge clock) begin
      if (cmd.scan_cmp && (idx_ff == '0 || obj_rd_ff < best_ff)) begin
         best_ff <= obj_rd_ff;
         low_ff  <= idx_ff[AW-1:0];
      end
      if (cmd.mul_prod) begin
         prod_ff <= smp_rd_ff * $signed({1'b0, stretch_ff});
      end
   end

   // Truncate toward zero, then saturate to 32 bits.
   assign prod_adj = prod_ff + (prod_ff[47] ? 48'sd255 : 48'sd0);
   assign prod_sh  = prod_adj >>> 8;
   assign mul_sat  = (prod_sh > MUL_MAX) ? OBJ_MAX :
                     (prod_sh < MUL_MIN) ? 32'sh8000_0000 : prod_sh[31:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_CURSOR: smp_ra = cursor_ff;
         RD_LAST:   smp_ra = last_w[AW-1:0];
         default:   smp_ra = idx_ff[AW-1:0];
      endcase
   end

   always_comb begin
      smp_we = 1'b0;
      smp_wa = idx_ff[AW-1:0];
      smp_wd = rq_pval_ff;
      case (cmd.smp_wr)
         SW_LOAD: begin
            smp_we = load_ok;
            smp_wa = load_ext[AW-1:0];
         end
         SW_MUL: begin
            smp_we = 1'b1;
            smp_wd = mul_sat;
         end
         SW_DIV: begin
            smp_we = 1'b1;
            smp_wd = div_quot;
         end
         default: ;
      endcase
   end

   always_comb begin
      obj_we = 1'b0;
      obj_wa = idx_ff[AW-1:0];
      obj_wd = OBJ_MAX;
      case (cmd.obj_wr)
         OW_MAX: begin
            obj_we = 1'b1;
         end
         OW_REPORT: begin
            obj_we = 1'b1;
            obj_wa = cursor_ff;
            obj_wd = rq_obj_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (smp_we) begin
         smp_mem[smp_wa] <= smp_wd;
      end
      smp_rd_ff <= smp_mem[smp_ra];
   end

   always_ff @(posedge clock) begin
      if (obj_we) begin
         obj_mem[obj_wa] <= obj_wd;
      end
      obj_rd_ff <= obj_mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         res_p1_ff   <= '0;
         res_p2_ff   <= '0;
         res_cnt_ff  <= '0;
         res_stat_ff <= STAT_OK;
      end else begin
         if (cmd.set_p1) begin
            res_p1_ff <= smp_rd_ff;
         end
         if (cmd.set_p2) begin
            res_p2_ff <= smp_rd_ff;
         end
         if (cmd.set_cnt) begin
            res_cnt_ff <= dim_ff;
         end
         if (cmd.set_status) begin
            res_stat_ff <= cmd.status_val;
         end
      end
   end

   // Output register: the next item may be taken while a result waits here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_p1_ff   <= res_p1_ff;
         rsp_p2_ff   <= res_p2_ff;
         rsp_cnt_ff  <= res_cnt_ff;
         rsp_stat_ff <= res_stat_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_param  = rsp_p1_ff;
   assign rsp_second_param = rsp_p2_ff;
   assign rsp_param_count  = rsp_cnt_ff;
   assign rsp_status_code  = rsp_stat_ff;

   always_comb begin
      stat             = '0;
      stat.rq_type     = rq_type_ff;
      stat.dim_mode    = dim_ff;
      stat.wrap        = wrap;
      stat.cursor_none = cursor_none_ff;
      stat.idx_last    = (idx_ff == last_w);
      stat.clear_last  = (idx_ff == CW'(TABLE_DEPTH - 1));
      stat.do_div      = (low_ff == '0) && (smp_rd_ff > init_min_ff);
      stat.do_mul      = (low_ff != '0) && (CW'(low_ff) == last_w);
      stat.div_done    = div_done;
      stat.param_match = (smp_rd_ff == rq_rparam_ff);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

>>> hw/rtl/adaptive_interval_sweep_tuner_top.sv
// Adaptive interval sweep tuner.
// Requests arrive on the req_ channel (valid/stall) and each produces exactly
// one result transfer on the rsp_ channel (valid/stall), in request order.
// Configuration registers are written through the csr_ channel (valid/ready,
// always ready) and should only be written while the block is idle.
// Items are handled one at a time by a controller that steps a datapath
// built around two table memories, each with one write port and one read port.
// A recommend that wraps the cursor first scans for the least objective,
// then may rescale the points (a multiply, or the 40-step serial divider)
// and then refills the objective table before it advances the cursor.
// After reset the block refills the objective table and stalls requests
// meanwhile; configuration writes are taken throughout.
// A finished result sits in an output register, so the next request can be
// taken while the receiver stalls; the block only waits when a second result
// is ready before the first has been transferred.
module adaptive_interval_sweep_tuner_top #(
   parameter int unsigned TABLE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic [5:0]         req_point_index,
   input  logic signed [31:0] req_point_value,
   input  logic signed [31:0] req_reported_param,
   input  logic signed [31:0] req_objective_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_first_param,
   output logic signed [31:0] rsp_second_param,
   output logic [1:0]         rsp_param_count,
   output logic [1:0]         rsp_status_code,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import aist_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   aist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   aist_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .req_type            (req_type),
      .req_point_index     (req_point_index),
      .req_point_value     (req_point_value),
      .req_reported_param  (req_reported_param),
      .req_objective_value (req_objective_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_first_param     (rsp_first_param),
      .rsp_second_param    (rsp_second_param),
      .rsp_param_count     (rsp_param_count),
      .rsp_status_code     (rsp_status_code),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule
